/* hw/rtl/sesc_pkg.sv */
package sesc_pkg;

   localparam int TPS_W   = 20;
   localparam int EPOCH_W = 38;
   localparam int ACC_W   = 40;
   localparam int COUNT_W = 4;

   localparam logic [TPS_W-1:0]   TPS_RESET       = 20'd1000000;
   localparam logic [EPOCH_W-1:0] MIN_EPOCH_RESET = 38'd1704067200;
   localparam logic [EPOCH_W-1:0] MAX_EPOCH_RESET = 38'd253402300799;

   localparam logic [COUNT_W-1:0] LEN_MIN   = 4'd10;
   localparam logic [COUNT_W-1:0] LEN_MAX   = 4'd12;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [1:0] {
      MODE_CHAR   = 2'd0,
      MODE_COMMIT = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_TICKS_PER_SECOND = 2'd0,
      CSR_MIN_EPOCH        = 2'd1,
      CSR_MAX_EPOCH        = 2'd2
   } csr_index_type;

   localparam logic KIND_COMMIT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic [TPS_W-1:0]   ticks_per_second;
      logic [EPOCH_W-1:0] min_epoch;
      logic [EPOCH_W-1:0] max_epoch;
   } cfg_type;

   typedef struct packed {
      logic               reply_kind;
      logic               sync_ok;
      logic               time_valid;
      logic [EPOCH_W-1:0] seconds;
   } rsp_type;

endpackage

/* hw/rtl/sesc_csr.sv */
module sesc_csr
   import sesc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [EPOCH_W-1:0]  csr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_data[TPS_W-1:0];
            CSR_MIN_EPOCH:        cfg_in.min_epoch        = csr_data;
            CSR_MAX_EPOCH:        cfg_in.max_epoch        = csr_data;
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second <= TPS_RESET;
         cfg_ff.min_epoch        <= MIN_EPOCH_RESET;
         cfg_ff.max_epoch        <= MAX_EPOCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/sesc_core.sv */
module sesc_core
   import sesc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  mode_type   mode,
   input  logic [7:0] char_code,
   input  cfg_type    cfg,
   output logic       has_result,
   output rsp_type    result
);

   logic [ACC_W-1:0]   digit_value_ff, digit_value_in;
   logic [COUNT_W-1:0] char_count_ff, char_count_in;
   logic               bad_char_ff, bad_char_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [TPS_W-1:0]   sub_second_ff, sub_second_in;
   logic               clock_valid_ff, clock_valid_in;

   logic               is_digit;
   logic [3:0]         char_offset;
   logic [ACC_W+3:0]   acc_wide;
   logic               sync_ok;
   logic [EPOCH_W-1:0] epoch_post;
   logic               valid_post;
   logic               valid_reply;
   logic [TPS_W-1:0]   sub_inc;

   assign is_digit    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign char_offset = 4'(char_code - CHAR_ZERO);
   // value * 10 + digit, kept wide so saturation can be seen
   assign acc_wide = {1'b0, digit_value_ff, 3'b000} + {3'b000, digit_value_ff, 1'b0}
                   + {{ACC_W{1'b0}}, char_offset};

   assign sync_ok = !bad_char_ff && (char_count_ff >= LEN_MIN) && (char_count_ff <= LEN_MAX)
                    && (digit_value_ff >= {2'b00, cfg.min_epoch})
                    && (digit_value_ff <= {2'b00, cfg.max_epoch});

   // on a query no sync is applied
   assign epoch_post  = (mode == MODE_COMMIT && sync_ok) ? digit_value_ff[EPOCH_W-1:0]
                                                         : epoch_ff;
   assign valid_post  = clock_valid_ff || (mode == MODE_COMMIT && sync_ok);
   assign valid_reply = valid_post && !(epoch_post > cfg.max_epoch);

   assign sub_inc = sub_second_ff + 1'b1;

   always_comb begin
      digit_value_in = digit_value_ff;
      char_count_in  = char_count_ff;
      bad_char_in    = bad_char_ff;
      epoch_in       = epoch_ff;
      sub_second_in  = sub_second_ff;
      clock_valid_in = clock_valid_ff;
      unique case (mode)
         MODE_CHAR: begin
            if (char_count_ff != COUNT_SAT) char_count_in = char_count_ff + 1'b1;
            if (!is_digit) begin
               bad_char_in = 1'b1;
            end else if (acc_wide[ACC_W+3:ACC_W] != 4'd0) begin
               digit_value_in = {ACC_W{1'b1}};
            end else begin
               digit_value_in = acc_wide[ACC_W-1:0];
            end
         end
         MODE_COMMIT: begin
            digit_value_in = '0;
            char_count_in  = '0;
            bad_char_in    = 1'b0;
            epoch_in       = epoch_post;
            if (sync_ok) sub_second_in = '0;
            clock_valid_in = valid_reply;
         end
         MODE_TICK: begin
            if (clock_valid_ff) begin
               if (sub_inc >= cfg.ticks_per_second) begin
                  sub_second_in = '0;
                  if (epoch_ff >= cfg.max_epoch) clock_valid_in = 1'b0;
                  else epoch_in = epoch_ff + 1'b1;
               end else begin
                  sub_second_in = sub_inc;
               end
            end
         end
         MODE_QUERY: begin
            clock_valid_in = valid_reply;
         end
         default: begin
            clock_valid_in = clock_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_value_ff <= '0;
         char_count_ff  <= '0;
         bad_char_ff    <= 1'b0;
         epoch_ff       <= '0;
         sub_second_ff  <= '0;
         clock_valid_ff <= 1'b0;
      end else if (fire) begin
         digit_value_ff <= digit_value_in;
         char_count_ff  <= char_count_in;
         bad_char_ff    <= bad_char_in;
         epoch_ff       <= epoch_in;
         sub_second_ff  <= sub_second_in;
         clock_valid_ff <= clock_valid_in;
      end
   end

   assign has_result        = (mode == MODE_COMMIT) || (mode == MODE_QUERY);
   assign result.reply_kind = (mode == MODE_QUERY) ? KIND_QUERY : KIND_COMMIT;
   assign result.sync_ok    = (mode == MODE_COMMIT) && sync_ok;
   assign result.time_valid = valid_reply;
   assign result.seconds    = valid_reply ? epoch_post : '0;

endmodule

/* hw/rtl/synced_epoch_seconds_clock.sv */
// Unix-seconds wall clock, set from a decimal string of 10 to 12 digits.
// Request channel (req_valid/req_ready): req_mode 0 carries one character
// of the sync string in req_char_code, 1 commits the string, 2 is one
// prescaler tick, 3 asks for the time. Commits and queries give one
// response on the rsp_ channel; characters and ticks give none.
// Configuration (csr_valid/csr_ready, always ready): index 0 ticks per
// second, 1 minimum epoch, 2 maximum epoch; other indexes are ignored.
// Write it only while no request is in flight.
// A request is registered in the input register on acceptance and is
// processed from there when it fires; its response then goes to the
// response register. One request can be accepted every cycle unless a
// response stall holds it; the rate rests on the state update after the
// input register. When the response register is full and rsp_ready is low,
// requests that produce a response wait in the input register and
// req_ready drops; characters and ticks still pass.
// Reset clears the clock to not synced and loads the default registers.
module synced_epoch_seconds_clock
   import sesc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_reply_kind,
   output logic               rsp_sync_ok,
   output logic               rsp_time_valid,
   output logic [EPOCH_W-1:0] rsp_seconds,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [EPOCH_W-1:0] csr_data
);

   logic       in_valid_ff, in_valid_in;
   mode_type   mode_ff;
   logic [7:0] char_code_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   cfg_type    cfg;
   rsp_type    result;
   logic       has_result;
   logic       out_free;
   logic       fire;

   assign csr_ready = 1'b1;

   sesc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sesc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .mode       (mode_ff),
      .char_code  (char_code_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (fire && has_result) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff      <= mode_type'(req_mode);
         char_code_ff <= req_char_code;
      end
      if (fire && has_result) rsp_ff <= result;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_ff.reply_kind;
   assign rsp_sync_ok    = rsp_ff.sync_ok;
   assign rsp_time_valid = rsp_ff.time_valid;
   assign rsp_seconds    = rsp_ff.seconds;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_ok_on_commit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_ok |-> rsp_reply_kind == KIND_COMMIT && rsp_time_valid)
      else $error("accepted sync outside a commit response or clock not valid");

   a_zero_invalid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_time_valid |-> rsp_seconds == '0)
      else $error("seconds reported while clock not valid");

   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && has_result && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response path blocked");

endmodule
